FILE: hdl/vn_pkg.sv
`default_nettype none
package vn_pkg;

    localparam int COMP_WIDTH = 16;
    localparam int FRAC_BITS  = 14;
    localparam int OUT_WIDTH  = FRAC_BITS + 2;
    localparam int DIM_WIDTH  = 3;
    localparam int LANES      = 4;

    // Sum of squares of up to four components, and the wide accumulators of the
    // root-and-divide search, with headroom for rejected trial values.
    localparam int SQ_WIDTH   = 2 * COMP_WIDTH;
    localparam int SUM_WIDTH  = 2 * COMP_WIDTH + 1;
    localparam int ACC_WIDTH  = 2 * COMP_WIDTH + 2 * FRAC_BITS + 6;
    localparam int QUO_WIDTH  = FRAC_BITS + 1;
    localparam int STAGES     = FRAC_BITS + 1;

    localparam int QDEPTH     = 8;
    localparam int QPTR_WIDTH = $clog2(QDEPTH);
    localparam int OCC_WIDTH  = $clog2(QDEPTH + 1);

    typedef logic [COMP_WIDTH-1:0] mag_t;
    typedef logic [SQ_WIDTH-1:0]   sq_t;
    typedef logic [SUM_WIDTH-1:0]  sum_t;
    typedef logic [ACC_WIDTH-1:0]  acc_t;
    typedef logic [QUO_WIDTH-1:0]  quo_t;

    // One classified vector, as it waits between the front and back parts.
    typedef struct packed {
        logic [LANES-1:0]  used;
        logic [LANES-1:0]  neg;
        logic              zero;
        sum_t              sum;
        sq_t [LANES-1:0]   sq;
    } work_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctl_t;

endpackage
`default_nettype wire

FILE: hdl/vn_req_if.sv
`default_nettype none
interface vn_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [vn_pkg::DIM_WIDTH-1:0]           dim;
    logic signed [vn_pkg::COMP_WIDTH-1:0]   comp0;
    logic signed [vn_pkg::COMP_WIDTH-1:0]   comp1;
    logic signed [vn_pkg::COMP_WIDTH-1:0]   comp2;
    logic signed [vn_pkg::COMP_WIDTH-1:0]   comp3;

    modport source (output valid, dim, comp0, comp1, comp2, comp3, input ready);
    modport sink   (input valid, dim, comp0, comp1, comp2, comp3, output ready);
endinterface
`default_nettype wire

FILE: hdl/vn_rsp_if.sv
`default_nettype none
interface vn_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [vn_pkg::OUT_WIDTH-1:0]    unit0;
    logic signed [vn_pkg::OUT_WIDTH-1:0]    unit1;
    logic signed [vn_pkg::OUT_WIDTH-1:0]    unit2;
    logic signed [vn_pkg::OUT_WIDTH-1:0]    unit3;
    logic                                   zero_vector;

    modport source (output valid, unit0, unit1, unit2, unit3, zero_vector, input ready);
    modport sink   (input valid, unit0, unit1, unit2, unit3, zero_vector, output ready);
endinterface
`default_nettype wire

FILE: hdl/vn_front.sv
`default_nettype none
module vn_front
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    vn_req_if.sink              req,
    input  wire logic           pop,
    output logic                push,
    output vn_pkg::work_t       push_data
);

    logic                                       accept;
    vn_pkg::mag_t [vn_pkg::LANES-1:0]           mag;
    logic [vn_pkg::LANES-1:0]                   used;
    logic [vn_pkg::LANES-1:0]                   neg;
    logic signed [vn_pkg::COMP_WIDTH-1:0]       comp [vn_pkg::LANES];

    logic                                       a_vld_reg;
    logic [vn_pkg::LANES-1:0]                   a_used_reg;
    logic [vn_pkg::LANES-1:0]                   a_neg_reg;
    vn_pkg::mag_t [vn_pkg::LANES-1:0]           a_mag_reg;

    logic                                       b_vld_reg;
    logic [vn_pkg::LANES-1:0]                   b_used_reg;
    logic [vn_pkg::LANES-1:0]                   b_neg_reg;
    logic                                       b_zero_reg;
    vn_pkg::sq_t [vn_pkg::LANES-1:0]            b_sq_reg;

    logic                                       c_vld_reg;
    vn_pkg::work_t                              c_work_reg;
    vn_pkg::sum_t                               sum;

    logic [vn_pkg::OCC_WIDTH-1:0]               occ_reg;
    logic [vn_pkg::OCC_WIDTH-1:0]               occ_next;

    // Items in flight here plus items held in the queue never exceed its depth.
    assign req.ready = (occ_reg < vn_pkg::OCC_WIDTH'(vn_pkg::QDEPTH));
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        comp[0] = req.comp0;
        comp[1] = req.comp1;
        comp[2] = req.comp2;
        comp[3] = req.comp3;
        // Dimensions below two act as two and above four act as four.
        used[0] = 1'b1;
        used[1] = 1'b1;
        used[2] = (req.dim >= vn_pkg::DIM_WIDTH'(3));
        used[3] = (req.dim >= vn_pkg::DIM_WIDTH'(4));
        for (int i = 0; i < vn_pkg::LANES; i++)
        begin
            neg[i] = used[i] && comp[i][vn_pkg::COMP_WIDTH-1];
            if (!used[i])
            begin
                mag[i] = '0;
            end
            else if (neg[i])
            begin
                mag[i] = ~vn_pkg::mag_t'(comp[i]) + vn_pkg::mag_t'(1);
            end
            else
            begin
                mag[i] = vn_pkg::mag_t'(comp[i]);
            end
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < vn_pkg::LANES; i++)
        begin
            sum = sum + vn_pkg::sum_t'(b_sq_reg[i]);
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (accept && !pop)
        begin
            occ_next = occ_reg + vn_pkg::OCC_WIDTH'(1);
        end
        else if (!accept && pop)
        begin
            occ_next = occ_reg - vn_pkg::OCC_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            occ_reg   <= '0;
        end
        else
        begin
            a_vld_reg <= accept;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_used_reg <= used;
        a_neg_reg  <= neg;
        a_mag_reg  <= mag;
        b_used_reg <= a_used_reg;
        b_neg_reg  <= a_neg_reg;
        b_zero_reg <= ~|a_mag_reg;
        for (int i = 0; i < vn_pkg::LANES; i++)
        begin
            b_sq_reg[i] <= vn_pkg::sq_t'(a_mag_reg[i]) * vn_pkg::sq_t'(a_mag_reg[i]);
        end
        c_work_reg.used <= b_used_reg;
        c_work_reg.neg  <= b_neg_reg;
        c_work_reg.zero <= b_zero_reg;
        c_work_reg.sum  <= sum;
        c_work_reg.sq   <= b_sq_reg;
    end

    assign push      = c_vld_reg;
    assign push_data = c_work_reg;

endmodule
`default_nettype wire

FILE: hdl/vn_queue.sv
`default_nettype none
module vn_queue
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire vn_pkg::queue_ctl_t ctl,
    input  wire vn_pkg::work_t      wr_data,
    output vn_pkg::work_t           head,
    output logic                    empty
);

    vn_pkg::work_t                      mem [vn_pkg::QDEPTH];
    vn_pkg::work_t                      head_reg;
    logic [vn_pkg::QPTR_WIDTH-1:0]      wr_ptr_reg;
    logic [vn_pkg::QPTR_WIDTH-1:0]      rd_ptr_reg;
    logic [vn_pkg::QPTR_WIDTH-1:0]      rd_ptr_next;
    logic [vn_pkg::OCC_WIDTH-1:0]       count_reg;

    assign empty       = (count_reg == '0);
    assign head        = head_reg;
    assign rd_ptr_next = rd_ptr_reg + vn_pkg::QPTR_WIDTH'(ctl.pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (ctl.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + vn_pkg::QPTR_WIDTH'(1);
            end
            if (ctl.pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + vn_pkg::QPTR_WIDTH'(1);
            end
            if (ctl.push && !ctl.pop)
            begin
                count_reg <= count_reg + vn_pkg::OCC_WIDTH'(1);
            end
            else if (!ctl.push && ctl.pop)
            begin
                count_reg <= count_reg - vn_pkg::OCC_WIDTH'(1);
            end
        end
    end

    // The head register always holds the entry at the read pointer; a write to
    // that very entry is passed straight through.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (ctl.push && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= wr_data;
        end
        else
        begin
            head_reg <= mem[rd_ptr_next];
        end
    end

endmodule
`default_nettype wire

FILE: hdl/vn_back.sv
`default_nettype none
module vn_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire vn_pkg::work_t  head,
    input  wire logic           empty,
    output logic                pop,
    vn_rsp_if.source            rsp
);

    typedef struct packed {
        logic [vn_pkg::LANES-1:0]           used;
        logic [vn_pkg::LANES-1:0]           neg;
        logic                               zero;
        vn_pkg::sum_t                       sum;
        vn_pkg::sq_t [vn_pkg::LANES-1:0]    sq;
        vn_pkg::acc_t [vn_pkg::LANES-1:0]   p;
        vn_pkg::acc_t [vn_pkg::LANES-1:0]   q;
        vn_pkg::quo_t [vn_pkg::LANES-1:0]   quo;
    } stage_t;

    // One bit of the result per stage. With x = 2*mid, p holds x*x*S and q holds
    // x*S; the trial bit is kept when (x-1)^2 * S <= mag^2 * 2^(2F+2).
    function automatic stage_t step(stage_t s, int b);
        stage_t         r;
        vn_pkg::acc_t   s_ext;
        vn_pkg::acc_t   q_n;
        vn_pkg::acc_t   p_n;
        vn_pkg::acc_t   test;
        vn_pkg::acc_t   rhs;
        r     = s;
        s_ext = vn_pkg::acc_t'(s.sum);
        for (int i = 0; i < vn_pkg::LANES; i++)
        begin
            q_n  = s.q[i] + (s_ext << (b + 1));
            p_n  = s.p[i] + (s.q[i] << (b + 2)) + (s_ext << (2 * b + 2));
            test = p_n - (q_n << 1) + s_ext;
            rhs  = vn_pkg::acc_t'(s.sq[i]) << (2 * vn_pkg::FRAC_BITS + 2);
            if (test <= rhs)
            begin
                r.p[i]      = p_n;
                r.q[i]      = q_n;
                r.quo[i][b] = 1'b1;
            end
        end
        return r;
    endfunction

    logic                           en;
    logic [vn_pkg::STAGES-1:0]      vld_reg;
    stage_t                         dat_reg [vn_pkg::STAGES];
    stage_t                         entry;

    logic                                           out_vld_reg;
    logic                                           out_zero_reg;
    logic signed [vn_pkg::OUT_WIDTH-1:0]            unit_reg [vn_pkg::LANES];

    assign en  = !out_vld_reg || rsp.ready;
    assign pop = en && !empty;

    always_comb
    begin
        entry      = '0;
        entry.used = head.used;
        entry.neg  = head.neg;
        entry.zero = head.zero;
        entry.sum  = head.sum;
        entry.sq   = head.sq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[vn_pkg::STAGES-2:0], !empty};
            out_vld_reg <= vld_reg[vn_pkg::STAGES-1];
        end
    end

    for (genvar k = 0; k < vn_pkg::STAGES; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dat_reg[k] <= step(entry, vn_pkg::FRAC_BITS);
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dat_reg[k] <= step(dat_reg[k-1], vn_pkg::FRAC_BITS - k);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_zero_reg <= dat_reg[vn_pkg::STAGES-1].zero;
            for (int i = 0; i < vn_pkg::LANES; i++)
            begin
                if (!dat_reg[vn_pkg::STAGES-1].used[i] || dat_reg[vn_pkg::STAGES-1].zero)
                begin
                    unit_reg[i] <= '0;
                end
                else if (dat_reg[vn_pkg::STAGES-1].neg[i])
                begin
                    unit_reg[i] <= -$signed({1'b0, dat_reg[vn_pkg::STAGES-1].quo[i]});
                end
                else
                begin
                    unit_reg[i] <= $signed({1'b0, dat_reg[vn_pkg::STAGES-1].quo[i]});
                end
            end
        end
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.unit0       = unit_reg[0];
    assign rsp.unit1       = unit_reg[1];
    assign rsp.unit2       = unit_reg[2];
    assign rsp.unit3       = unit_reg[3];
    assign rsp.zero_vector = out_zero_reg;

endmodule
`default_nettype wire

FILE: hdl/vector_normalize.sv
// Channel | Dir | Payload                               | Handshake
// req     | in  | dim, comp0..comp3                     | valid/ready
// rsp     | out | unit0..unit3 (Q1.14), zero_vector     | valid/ready
//
// One vector is accepted per cycle while ready is high; each result passes
// through 3 front stages, the queue, 15 result-bit stages (one bit per stage)
// and the output register.
// Reset is asynchronous and clears all valid state; no clearing pass is needed.
// A stalled response freezes the back pipeline; the 8-entry queue absorbs the
// front, which withholds ready once eight requests sit in the front stages and
// the queue together.
`default_nettype none
module vector_normalize
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    vn_req_if.sink      req,
    vn_rsp_if.source    rsp
);

    vn_pkg::queue_ctl_t     qctl;
    vn_pkg::work_t          push_data;
    vn_pkg::work_t          head;
    logic                   empty;
    logic                   push;
    logic                   pop;

    assign qctl.push = push;
    assign qctl.pop  = pop;

    vn_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .pop       (pop),
        .push      (push),
        .push_data (push_data)
    );

    vn_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (qctl),
        .wr_data (push_data),
        .head    (head),
        .empty   (empty)
    );

    vn_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule
`default_nettype wire

FILE: hdl/vn_checker.sv
`default_nettype none
module vn_checker
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   rsp_valid,
    input  wire logic                                   rsp_ready,
    input  wire logic signed [vn_pkg::OUT_WIDTH-1:0]    rsp_unit0,
    input  wire logic signed [vn_pkg::OUT_WIDTH-1:0]    rsp_unit1,
    input  wire logic signed [vn_pkg::OUT_WIDTH-1:0]    rsp_unit2,
    input  wire logic signed [vn_pkg::OUT_WIDTH-1:0]    rsp_unit3,
    input  wire logic                                   rsp_zero_vector
);

    localparam logic signed [vn_pkg::OUT_WIDTH-1:0] UNIT_MAX =
        vn_pkg::OUT_WIDTH'(1 << vn_pkg::FRAC_BITS);
    localparam logic signed [vn_pkg::OUT_WIDTH-1:0] UNIT_MIN = -UNIT_MAX;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_zero_vector |->
            rsp_unit0 == '0 && rsp_unit1 == '0 && rsp_unit2 == '0 && rsp_unit3 == '0)
        else $error("zero vector with nonzero components");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |->
            rsp_unit0 <= UNIT_MAX && rsp_unit0 >= UNIT_MIN &&
            rsp_unit1 <= UNIT_MAX && rsp_unit1 >= UNIT_MIN &&
            rsp_unit2 <= UNIT_MAX && rsp_unit2 >= UNIT_MIN &&
            rsp_unit3 <= UNIT_MAX && rsp_unit3 >= UNIT_MIN)
        else $error("unit component beyond one");

    a_reset: assert property (@(posedge clk)
        !$past(rst_n) |-> !rsp_valid)
        else $error("response valid right after reset");

endmodule

bind vector_normalize vn_checker u_vn_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_unit0       (rsp.unit0),
    .rsp_unit1       (rsp.unit1),
    .rsp_unit2       (rsp.unit2),
    .rsp_unit3       (rsp.unit3),
    .rsp_zero_vector (rsp.zero_vector)
);
`default_nettype wire
